// ===== src/bff_pkg.sv =====
// Shared types, constants and the microcode table of the boundary fill raster engine.
package bff_pkg;

  localparam int COLOR_W = 24;
  localparam int COUNT_W = 17;
  localparam int STEP_W  = 5;
  localparam int CFG_IDX_W = 8;

  localparam logic [COLOR_W-1:0] WHITE          = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] FILL_RESET     = 24'hFF0000;
  localparam logic [COLOR_W-1:0] BOUNDARY_RESET = 24'h000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_COLOR = 8'd1;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_FILL  = 2'd2;

  localparam logic [STEP_W-1:0] ST_CLR0  = 5'd0;
  localparam logic [STEP_W-1:0] ST_CLR1  = 5'd1;
  localparam logic [STEP_W-1:0] ST_IDLE  = 5'd2;
  localparam logic [STEP_W-1:0] ST_DISP  = 5'd3;
  localparam logic [STEP_W-1:0] ST_DISP1 = 5'd4;
  localparam logic [STEP_W-1:0] ST_DISP2 = 5'd5;
  localparam logic [STEP_W-1:0] ST_WR0   = 5'd6;
  localparam logic [STEP_W-1:0] ST_WR1   = 5'd7;
  localparam logic [STEP_W-1:0] ST_RD0   = 5'd8;
  localparam logic [STEP_W-1:0] ST_RD1   = 5'd9;
  localparam logic [STEP_W-1:0] ST_FILL0 = 5'd10;
  localparam logic [STEP_W-1:0] ST_LOOP  = 5'd11;
  localparam logic [STEP_W-1:0] ST_POP   = 5'd12;
  localparam logic [STEP_W-1:0] ST_LDPOP = 5'd13;
  localparam logic [STEP_W-1:0] ST_ADDR  = 5'd14;
  localparam logic [STEP_W-1:0] ST_RDPIX = 5'd15;
  localparam logic [STEP_W-1:0] ST_TEST  = 5'd16;
  localparam logic [STEP_W-1:0] ST_PAINT = 5'd17;
  localparam logic [STEP_W-1:0] ST_PSHN  = 5'd18;
  localparam logic [STEP_W-1:0] ST_PSHE  = 5'd19;
  localparam logic [STEP_W-1:0] ST_PSHW  = 5'd20;
  localparam logic [STEP_W-1:0] ST_OVF   = 5'd21;
  localparam logic [STEP_W-1:0] ST_DONE  = 5'd22;
  localparam logic [STEP_W-1:0] ST_WAIT  = 5'd23;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [COLOR_W-1:0] pixel_color;
  } bff_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [COUNT_W-1:0] painted_count;
    logic               stack_overflow;
  } bff_out_t;

  typedef enum logic [3:0] {
    C_NEXT, C_ALWAYS, C_NO_ITEM, C_NOT_LAST, C_FN_FILL, C_FN_READ, C_NOT_WRITE,
    C_SEED_OUT, C_PIX_SKIP, C_SP_ZERO, C_NO_OVF, C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {AD_HOLD, AD_ZERO, AD_INC, AD_XY} addr_op_t;

  typedef enum logic [1:0] {WS_WHITE, WS_PIXEL, WS_FILL} wsel_t;

  typedef enum logic [2:0] {
    PS_NONE, PS_SEED, PS_SOUTH, PS_NORTH, PS_EAST, PS_WEST
  } push_t;

  typedef struct packed {
    logic     ld_item;
    addr_op_t addr_op;
    logic     fr_we;
    wsel_t    wsel;
    logic     fr_rd;
    logic     pop;
    logic     ld_pop;
    push_t    push;
    logic     cnt_inc;
    logic     ld_color;
    logic     sp_clr;
    logic     out_ld;
  } dp_ctrl_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    dp_ctrl_t          dp;
  } ucw_t;

  typedef struct packed {
    logic fn_fill;
    logic fn_read;
    logic fn_write;
    logic seed_out;
    logic not_last;
    logic pix_skip;
    logic sp_zero;
    logic ovf;
  } stat_t;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    unique case (step)
      ST_CLR0: begin
        w.dp.addr_op = AD_ZERO;
      end
      ST_CLR1: begin
        w.dp.fr_we   = 1'b1;
        w.dp.wsel    = WS_WHITE;
        w.dp.addr_op = AD_INC;
        w.cond       = C_NOT_LAST;
        w.target     = ST_CLR1;
      end
      ST_IDLE: begin
        w.dp.ld_item = 1'b1;
        w.cond       = C_NO_ITEM;
        w.target     = ST_IDLE;
      end
      ST_DISP: begin
        w.dp.addr_op = AD_XY;
        w.cond       = C_FN_FILL;
        w.target     = ST_FILL0;
      end
      ST_DISP1: begin
        w.cond   = C_FN_READ;
        w.target = ST_RD0;
      end
      ST_DISP2: begin
        w.cond   = C_NOT_WRITE;
        w.target = ST_DONE;
      end
      ST_WR0: begin
        w.cond   = C_SEED_OUT;
        w.target = ST_DONE;
      end
      ST_WR1: begin
        w.dp.fr_we = 1'b1;
        w.dp.wsel  = WS_PIXEL;
        w.cond     = C_ALWAYS;
        w.target   = ST_DONE;
      end
      ST_RD0: begin
        w.dp.fr_rd = 1'b1;
        w.cond     = C_SEED_OUT;
        w.target   = ST_DONE;
      end
      ST_RD1: begin
        w.dp.ld_color = 1'b1;
        w.cond        = C_ALWAYS;
        w.target      = ST_DONE;
      end
      ST_FILL0: begin
        w.dp.push = PS_SEED;
      end
      ST_LOOP: begin
        w.cond   = C_SP_ZERO;
        w.target = ST_DONE;
      end
      ST_POP: begin
        w.dp.pop = 1'b1;
      end
      ST_LDPOP: begin
        w.dp.ld_pop = 1'b1;
      end
      ST_ADDR: begin
        w.dp.addr_op = AD_XY;
      end
      ST_RDPIX: begin
        w.dp.fr_rd = 1'b1;
      end
      ST_TEST: begin
        w.cond   = C_PIX_SKIP;
        w.target = ST_LOOP;
      end
      ST_PAINT: begin
        w.dp.fr_we   = 1'b1;
        w.dp.wsel    = WS_FILL;
        w.dp.cnt_inc = 1'b1;
        w.dp.push    = PS_SOUTH;
      end
      ST_PSHN: begin
        w.dp.push = PS_NORTH;
      end
      ST_PSHE: begin
        w.dp.push = PS_EAST;
      end
      ST_PSHW: begin
        w.dp.push = PS_WEST;
        w.cond    = C_NO_OVF;
        w.target  = ST_LOOP;
      end
      ST_OVF: begin
        w.dp.sp_clr = 1'b1;
      end
      ST_DONE: begin
        w.dp.out_ld = 1'b1;
        w.cond      = C_OUT_FREE;
        w.target    = ST_IDLE;
      end
      ST_WAIT: begin
        w.cond   = C_ALWAYS;
        w.target = ST_DONE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/bff_seq.sv =====
// Microcode sequencer: step counter, control table fetch and conditional jumps.
module bff_seq
  import bff_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  stat_t    stat,
  input  logic     in_valid,
  input  logic     out_busy,
  output logic     idle,
  output dp_ctrl_t ctrl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucw_t              w;
  logic              take;

  assign w = ucode_rom(step_r);

  always_comb begin
    unique case (w.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ITEM:   take = !in_valid;
      C_NOT_LAST:  take = stat.not_last;
      C_FN_FILL:   take = stat.fn_fill;
      C_FN_READ:   take = stat.fn_read;
      C_NOT_WRITE: take = !stat.fn_write;
      C_SEED_OUT:  take = stat.seed_out;
      C_PIX_SKIP:  take = stat.pix_skip;
      C_SP_ZERO:   take = stat.sp_zero;
      C_NO_OVF:    take = !stat.ovf;
      C_OUT_FREE:  take = !out_busy;
      default:     take = 1'b1;
    endcase
    step_nxt = take ? w.target : step_r + STEP_W'(1);
  end

  always_comb begin
    ctrl         = w.dp;
    ctrl.ld_item = w.dp.ld_item && in_valid;
    ctrl.out_ld  = w.dp.out_ld && !out_busy;
  end

  assign idle = w.dp.ld_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLR0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/bff_dpath.sv =====
// Datapath: item registers, frame store, coordinate stack and fill counters.
module bff_dpath
  import bff_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int STACK_DEPTH  = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctrl_t           ctrl,
  input  bff_in_t            item,
  input  logic [COLOR_W-1:0] fill_color,
  input  logic [COLOR_W-1:0] boundary_color,
  output stat_t              stat,
  output bff_out_t           res
);

  localparam int FRAME_PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(FRAME_PIX);
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);
  localparam int CW  = XW + YW;
  localparam int STW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [COLOR_W-1:0] frame_mem [FRAME_PIX];
  logic [CW-1:0]      stack_mem [STACK_DEPTH];

  logic [1:0]         func_r;
  logic [COLOR_W-1:0] color_r;
  logic               inf_r;
  logic [XW-1:0]      cx_r;
  logic [YW-1:0]      cy_r;
  logic [AW-1:0]      addr_r;
  logic [COLOR_W-1:0] pix_r;
  logic [CW-1:0]      st_rd_r;
  logic [SPW-1:0]     sp_r;
  logic [SPW-1:0]     sp_dec;
  logic [COUNT_W-1:0] count_r;
  logic               ovf_r;
  logic [COLOR_W-1:0] res_color_r;

  logic [COLOR_W-1:0] wdata;
  logic [XW-1:0]      nx;
  logic [YW-1:0]      ny;
  logic               nv;
  logic               push_full;
  logic               push_we;

  assign sp_dec = sp_r - SPW'(1);

  always_comb begin
    case (ctrl.wsel)
      WS_WHITE: wdata = WHITE;
      WS_PIXEL: wdata = color_r;
      WS_FILL:  wdata = fill_color;
      default:  wdata = WHITE;
    endcase
  end

  always_comb begin
    nx = cx_r;
    ny = cy_r;
    nv = 1'b0;
    case (ctrl.push)
      PS_SEED: begin
        nv = inf_r;
      end
      PS_SOUTH: begin
        ny = cy_r + YW'(1);
        nv = cy_r != YW'(FRAME_HEIGHT - 1);
      end
      PS_NORTH: begin
        ny = cy_r - YW'(1);
        nv = cy_r != '0;
      end
      PS_EAST: begin
        nx = cx_r + XW'(1);
        nv = cx_r != XW'(FRAME_WIDTH - 1);
      end
      PS_WEST: begin
        nx = cx_r - XW'(1);
        nv = cx_r != '0;
      end
      default: begin
        nv = 1'b0;
      end
    endcase
  end

  assign push_full = sp_r == SPW'(STACK_DEPTH);
  assign push_we   = nv && !push_full;

  always_ff @(posedge clk) begin
    if (ctrl.fr_we) begin
      frame_mem[addr_r] <= wdata;
    end
    if (ctrl.fr_rd) begin
      pix_r <= frame_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      stack_mem[sp_r[STW-1:0]] <= {ny, nx};
    end
    if (ctrl.pop) begin
      st_rd_r <= stack_mem[sp_dec[STW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (ctrl.sp_clr) begin
      sp_r <= '0;
    end else if (push_we) begin
      sp_r <= sp_r + SPW'(1);
    end else if (ctrl.pop) begin
      sp_r <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_item) begin
      func_r      <= item.func;
      color_r     <= item.pixel_color;
      inf_r       <= (32'(item.pos_x) < 32'(FRAME_WIDTH)) &&
                     (32'(item.pos_y) < 32'(FRAME_HEIGHT));
      cx_r        <= XW'(32'(item.pos_x));
      cy_r        <= YW'(32'(item.pos_y));
      count_r     <= '0;
      ovf_r       <= 1'b0;
      res_color_r <= '0;
    end else begin
      if (ctrl.ld_pop) begin
        {cy_r, cx_r} <= st_rd_r;
      end
      if (ctrl.cnt_inc && count_r != COUNT_MAX) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (nv && push_full) begin
        ovf_r <= 1'b1;
      end
      if (ctrl.ld_color) begin
        res_color_r <= pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.addr_op)
      AD_ZERO: addr_r <= '0;
      AD_INC:  addr_r <= addr_r + AW'(1);
      AD_XY:   addr_r <= AW'(32'(cy_r) * 32'(FRAME_WIDTH) + 32'(cx_r));
      default: addr_r <= addr_r;
    endcase
  end

  always_comb begin
    stat.fn_fill  = func_r == FN_FILL;
    stat.fn_read  = func_r == FN_READ;
    stat.fn_write = func_r == FN_WRITE;
    stat.seed_out = !inf_r;
    stat.not_last = addr_r != AW'(FRAME_PIX - 1);
    stat.pix_skip = (pix_r == fill_color) || (pix_r == boundary_color);
    stat.sp_zero  = sp_r == '0;
    stat.ovf      = ovf_r || (nv && push_full);
  end

  always_comb begin
    res.read_color     = res_color_r;
    res.painted_count  = count_r;
    res.stack_overflow = ovf_r;
  end

endmodule

// ===== src/boundary_fill_4_connected.sv =====
// Top level of the raster engine with a 4-connected boundary fill.
// After reset a clearing pass paints every pixel white, one per cycle; no item is taken meanwhile.
// A read item reads the frame store and loads the colour; a write item writes its pixel colour.
// A fill pushes an on-frame seed, then pops coordinates, painting each pixel not yet in the fill or
// boundary colour and pushing its in-frame neighbours. The next item can be taken in the cycle after a
// result is loaded; no result is loaded while out_stall holds the previous one.
module boundary_fill_4_connected
  import bff_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int STACK_DEPTH  = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bff_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bff_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  logic [COLOR_W-1:0] fill_col_r;
  logic [COLOR_W-1:0] boundary_col_r;
  logic               out_valid_r;
  bff_out_t           out_data_r;
  logic               out_busy;
  logic               idle;
  dp_ctrl_t           ctrl;
  stat_t              stat;
  bff_out_t           res;

  assign cfg_ready    = 1'b1;
  assign out_busy     = out_valid_r && out_stall;
  assign in_stall     = !idle;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_col_r     <= FILL_RESET;
      boundary_col_r <= BOUNDARY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FILL_COLOR) begin
        fill_col_r <= cfg_data;
      end else if (cfg_index == CFG_BOUNDARY_COLOR) begin
        boundary_col_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_data_r <= res;
    end
  end

  bff_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  bff_dpath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .item           (in_data),
    .fill_color     (fill_col_r),
    .boundary_color (boundary_col_r),
    .stat           (stat),
    .res            (res)
  );

endmodule

// ===== test/bff_monitor.sv =====
`timescale 1ns / 100ps
// Channel monitor that predicts every result of the boundary fill raster engine and checks it.
module bff_monitor
  import bff_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int STACK_DEPTH  = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  bff_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  bff_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int                   results_due,
  output int                   failures
);

  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int REPORT_LIMIT = 10;

  logic [COLOR_W-1:0] pixels [PIXELS];
  int                 fill_stack [STACK_DEPTH];
  logic [COLOR_W-1:0] paint_colour;
  logic [COLOR_W-1:0] stop_colour;
  bff_out_t           raster_results_due [$];
  int                 errors;
  int                 results_seen;

  function automatic bff_out_t raster_step(input bff_in_t it);
    bff_out_t r;
    int       depth;
    int       spot;
    int       tx;
    int       ty;
    int       k;
    int       painted;
    bit       full;
    bit       on_frame;
    r        = '0;
    depth    = 0;
    painted  = 0;
    full     = 1'b0;
    on_frame = (int'(it.pos_x) < FRAME_WIDTH) && (int'(it.pos_y) < FRAME_HEIGHT);
    spot     = int'(it.pos_y) * FRAME_WIDTH + int'(it.pos_x);
    case (it.func)
      FN_WRITE: begin
        if (on_frame) pixels[spot] = it.pixel_color;
      end
      FN_READ: begin
        if (on_frame) r.read_color = pixels[spot];
      end
      FN_FILL: begin
        if (on_frame) begin
          fill_stack[0] = spot;
          depth = 1;
        end
        while (!full && depth > 0) begin
          depth--;
          spot = fill_stack[depth];
          if (pixels[spot] != paint_colour && pixels[spot] != stop_colour) begin
            pixels[spot] = paint_colour;
            painted++;
            for (k = 0; k < 4 && !full; k++) begin
              tx = spot % FRAME_WIDTH;
              ty = spot / FRAME_WIDTH;
              case (k)
                0: ty = ty + 1;
                1: ty = ty - 1;
                2: tx = tx + 1;
                default: tx = tx - 1;
              endcase
              if (tx >= 0 && tx < FRAME_WIDTH && ty >= 0 && ty < FRAME_HEIGHT) begin
                if (depth >= STACK_DEPTH) begin
                  full = 1'b1;
                end else begin
                  fill_stack[depth] = ty * FRAME_WIDTH + tx;
                  depth++;
                end
              end
            end
          end
        end
        r.painted_count  = (painted > int'(COUNT_MAX)) ? COUNT_MAX : painted[COUNT_W-1:0];
        r.stack_overflow = full;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    bff_out_t want;
    if (!rst_n) begin
      paint_colour = FILL_RESET;
      stop_colour  = BOUNDARY_RESET;
      for (int i = 0; i < PIXELS; i++) pixels[i] = WHITE;
      raster_results_due.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FILL_COLOR) begin
          paint_colour = cfg_data;
        end else if (cfg_index == CFG_BOUNDARY_COLOR) begin
          stop_colour = cfg_data;
        end
      end
      if (in_valid && !in_stall)
        raster_results_due.insert(raster_results_due.size(), raster_step(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (raster_results_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("result %0d arrived with nothing outstanding: colour %h count %0d ovf %b",
                     results_seen, out_data.read_color, out_data.painted_count,
                     out_data.stack_overflow);
        end else begin
          want = raster_results_due.pop_front();
          if (want.read_color !== out_data.read_color ||
              want.painted_count !== out_data.painted_count ||
              want.stack_overflow !== out_data.stack_overflow) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("result %0d wrong: expected colour %h count %0d ovf %b, got %h %0d %b",
                       results_seen, want.read_color, want.painted_count, want.stack_overflow,
                       out_data.read_color, out_data.painted_count, out_data.stack_overflow);
          end
        end
      end
    end
    results_due <= raster_results_due.size();
    failures    <= errors;
  end

endmodule

// ===== test/tb_boundary_fill_4_connected.sv =====
`timescale 1ns / 100ps
// Top-level stimulus, clock, reset and verdict for the boundary fill raster engine.
module tb_boundary_fill_4_connected;
  import bff_pkg::*;

  localparam int FRAME_WIDTH   = 256;
  localparam int FRAME_HEIGHT  = 256;
  localparam int STACK_DEPTH   = 4096;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 280;
  localparam logic [1:0]           FN_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bff_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bff_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;

  int                 results_due;
  int                 failures;
  int                 cycle_count = 0;
  int                 send_idle   = 24;
  int                 recv_idle   = 62;
  int                 items_sent;
  int                 open_fills_left;
  bit                 hold_req    = 1'b0;
  logic [COLOR_W-1:0] fill_col    = FILL_RESET;
  logic [COLOR_W-1:0] bnd_col     = BOUNDARY_RESET;

  always #1 clk = ~clk;

  boundary_fill_4_connected #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  bff_monitor #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .results_due(results_due),
    .failures   (failures)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("boundary_fill_4_connected: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic issue_item(input logic [1:0] fn, input int x, input int y,
                            input logic [COLOR_W-1:0] colour);
    bff_in_t it;
    it.func        = fn;
    it.pos_x       = x[7:0];
    it.pos_y       = y[7:0];
    it.pixel_color = colour;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_registers(input logic [COLOR_W-1:0] fc, input logic [COLOR_W-1:0] bc,
                                 input bit poke_unused);
    cfg_write(CFG_FILL_COLOR, fc);
    cfg_write(CFG_BOUNDARY_COLOR, bc);
    if (poke_unused) cfg_write(CFG_UNUSED, COLOR_W'($urandom()));
    cfg_valid <= 1'b0;
    fill_col = fc;
    bnd_col  = bc;
  endtask

  function automatic logic [COLOR_W-1:0] pick_colour();
    case ($urandom_range(5))
      0: return fill_col;
      1: return bnd_col;
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  // An outline in the boundary colour encloses a small region; a side lying on the
  // frame edge is left open so that the edge itself bounds the region.
  task automatic draw_box_and_fill();
    int w;
    int h;
    int x0;
    int y0;
    int i;
    int n;
    w = $urandom_range(3, 10);
    h = $urandom_range(3, 10);
    case ($urandom_range(7))
      0: x0 = 0;
      1: x0 = FRAME_WIDTH - w;
      default: x0 = $urandom_range(FRAME_WIDTH - w);
    endcase
    case ($urandom_range(7))
      0: y0 = 0;
      1: y0 = FRAME_HEIGHT - h;
      default: y0 = $urandom_range(FRAME_HEIGHT - h);
    endcase
    for (i = x0; i < x0 + w; i++) begin
      if (y0 != 0) issue_item(FN_WRITE, i, y0, bnd_col);
      if (y0 + h != FRAME_HEIGHT) issue_item(FN_WRITE, i, y0 + h - 1, bnd_col);
    end
    for (i = y0; i < y0 + h; i++) begin
      if (x0 != 0) issue_item(FN_WRITE, x0, i, bnd_col);
      if (x0 + w != FRAME_WIDTH) issue_item(FN_WRITE, x0 + w - 1, i, bnd_col);
    end
    n = $urandom_range(2);
    repeat (n)
      issue_item(FN_WRITE, $urandom_range(x0 + 1, x0 + w - 2),
                 $urandom_range(y0 + 1, y0 + h - 2), pick_colour());
    issue_item(FN_FILL, $urandom_range(x0 + 1, x0 + w - 2),
               $urandom_range(y0 + 1, y0 + h - 2), COLOR_W'($urandom()));
    n = $urandom_range(1, 3);
    repeat (n)
      issue_item(FN_READ, $urandom_range(x0, x0 + w - 1), $urandom_range(y0, y0 + h - 1),
                 COLOR_W'($urandom()));
  endtask

  task automatic scatter_item();
    int x;
    int y;
    int sel;
    x   = $urandom_range(FRAME_WIDTH - 1);
    y   = $urandom_range(FRAME_HEIGHT - 1);
    sel = $urandom_range(99);
    if (sel < 35) begin
      issue_item(FN_WRITE, x, y, pick_colour());
    end else if (sel < 65) begin
      issue_item(FN_READ, x, y, COLOR_W'($urandom()));
    end else if (sel < 72) begin
      issue_item(FN_NONE, x, y, COLOR_W'($urandom()));
    end else if (sel < 86) begin
      issue_item(FN_WRITE, x, y, bnd_col);
      issue_item(FN_FILL, x, y, COLOR_W'($urandom()));
    end else if (sel < 98 || open_fills_left == 0) begin
      issue_item(FN_WRITE, x, y, fill_col);
      issue_item(FN_FILL, x, y, COLOR_W'($urandom()));
    end else begin
      open_fills_left--;
      issue_item(FN_FILL, x, y, COLOR_W'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    issue_item(FN_READ, 0, 0, '0);
    issue_item(FN_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, WHITE);
    issue_item(FN_WRITE, 0, 0, 24'h123456);
    issue_item(FN_READ, 0, 0, '0);
    issue_item(FN_WRITE, 1, 0, BOUNDARY_RESET);
    issue_item(FN_WRITE, 0, 1, BOUNDARY_RESET);
    issue_item(FN_FILL, 0, 0, '0);
    issue_item(FN_READ, 0, 0, '0);
    issue_item(FN_FILL, 0, 0, '0);
    issue_item(FN_FILL, 1, 0, '0);
    issue_item(FN_WRITE, FRAME_WIDTH - 2, FRAME_HEIGHT - 1, 24'h000000);
    issue_item(FN_WRITE, FRAME_WIDTH - 1, FRAME_HEIGHT - 2, 24'h000000);
    issue_item(FN_WRITE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 24'hFFFFFF);
    issue_item(FN_FILL, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, WHITE);
    issue_item(FN_NONE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 24'hFFFFFF);
    issue_item(FN_NONE, 0, 0, '0);
    issue_item(FN_FILL, FRAME_WIDTH / 2, FRAME_HEIGHT / 2, '0);
    issue_item(FN_READ, FRAME_WIDTH / 2, FRAME_HEIGHT / 2, '0);
    issue_item(FN_WRITE, FRAME_WIDTH - 1, 0, 24'hFFFFFF);
    issue_item(FN_READ, FRAME_WIDTH - 1, 0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle = (phase < 2) ? 24 : (phase < 4) ? 62 : 0;
      recv_idle = (phase < 2) ? 62 : (phase < 4) ? 24 : 0;
      case (phase)
        0: write_registers(COLOR_W'($urandom()), COLOR_W'($urandom()), 1'b1);
        1: write_registers(WHITE, 24'h000000, 1'b0);
        2: write_registers(24'h000000, WHITE, 1'b0);
        3: begin
          fill_col = COLOR_W'($urandom());
          write_registers(fill_col, fill_col, 1'b0);
        end
        4: write_registers(COLOR_W'($urandom()), COLOR_W'($urandom()), 1'b1);
        default: write_registers(FILL_RESET, BOUNDARY_RESET, 1'b0);
      endcase
      open_fills_left = 1;
      items_sent      = 0;
      if (phase == 4) hold_req = 1'b1;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 10) draw_box_and_fill();
        else scatter_item();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("boundary_fill_4_connected: match");
    end else begin
      $display("boundary_fill_4_connected: mismatch");
    end
    $finish;
  end

endmodule
